>>> src/rle4_pkg.sv
`timescale 1ns / 1ps
// rle4_pkg: shared types, constants and helpers of the 4bpp row RLE decoder.
// No dependencies.
package rle4_pkg;

    localparam int OUT_BYTES_DEF = 4;
    localparam int QDEPTH        = 2;
    localparam int WIDTH_W       = 15;
    localparam int HEIGHT_W      = 8;
    localparam int ROW_W         = 15;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [7:0] RUN_MARK = 8'h80;
    localparam logic [8:0] RUN_BASE = 9'd257;

    typedef enum logic [1:0] {
        OP_CMD = 2'd0,
        OP_RUN = 2'd1,
        OP_LIT = 2'd2
    } op_kind_t;

    // One classified request from the parser to the row builder.
    // OP_CMD: data is the byte count of the command, flag set for a run.
    // OP_RUN: data is the byte to repeat.
    // OP_LIT: data is the literal, flag set on the last literal of the command.
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       flag;
    } op_t;

    // Row pitch in bytes: 2*ceil(w/4), a width of zero counts as one.
    function automatic logic [ROW_W-1:0] row_pitch(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W:0]   w_eff;
        logic [WIDTH_W-2:0] quads;
        begin
            w_eff = (w == '0) ? (WIDTH_W+1)'(1) : {1'b0, w};
            quads = (WIDTH_W-1)'((w_eff + (WIDTH_W+1)'(3)) >> 2);
            row_pitch = {quads, 1'b0};
        end
    endfunction

endpackage

>>> src/rle_4bpp_row_decoder.sv
`timescale 1ns / 1ps
// rle_4bpp_row_decoder: top level of the packed 4bpp row RLE decoder.
// Depends on rle4_pkg, rle4_front, rle4_queue, rle4_back.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_stall     data_byte
//   out      source     out_valid / out_stall   pixel_bytes, byte_count, row_end,
//                                               image_end, overrun_seen
//   cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Command, literal and skipped bytes each use up one queue entry in the row builder.
// A run value byte expands to 2..129 bytes, cut at the row end; the builder produces
// one decoded byte per cycle while out_stall does not hold it.
// A two-entry request queue separates parser and builder; in_stall rises when it is full.
// out_stall freezes the builder while a word waits in the output register.
// Reset clears all control state; width and height reset to 1.
module rle_4bpp_row_decoder
    import rle4_pkg::*;
#(
    parameter int OUT_BYTES = OUT_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [31:0]  pixel_bytes,
    output logic [2:0]   byte_count,
    output logic         row_end,
    output logic         image_end,
    output logic         overrun_seen,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                q_full, head_valid, pop, accept;
    op_t                 front_op, head_op;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    rle4_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .op        (front_op)
    );

    rle4_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_op    (front_op),
        .full       (q_full),
        .pop        (pop),
        .head_op    (head_op),
        .head_valid (head_valid)
    );

    rle4_back #(
        .OUT_BYTES (OUT_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_op      (head_op),
        .head_valid   (head_valid),
        .pop          (pop),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_bytes  (pixel_bytes),
        .byte_count   (byte_count),
        .row_end      (row_end),
        .image_end    (image_end),
        .overrun_seen (overrun_seen)
    );

endmodule

>>> src/rle4_front.sv
`timescale 1ns / 1ps
// rle4_front: command parser; classifies each stream byte into a request.
// Depends on rle4_pkg.
module rle4_front
    import rle4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output op_t        op
);

    typedef enum logic [2:0] {
        F_CMD = 3'b001,
        F_RUN = 3'b010,
        F_LIT = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [7:0]   lit_left_reg, lit_left_next;
    logic [7:0]   cmd_cnt;
    logic         is_run;

    assign is_run  = (data_byte & RUN_MARK) != 8'd0;
    assign cmd_cnt = is_run ? 8'(RUN_BASE - {1'b0, data_byte}) : data_byte + 8'd1;

    always_comb
    begin
        state_next    = state_reg;
        lit_left_next = lit_left_reg;
        op.kind       = OP_CMD;
        op.data       = cmd_cnt;
        op.flag       = is_run;
        case (state_reg)
            F_CMD:
            begin
                if (accept)
                begin
                    state_next    = is_run ? F_RUN : F_LIT;
                    lit_left_next = cmd_cnt;
                end
            end
            F_RUN:
            begin
                op.kind = OP_RUN;
                op.data = data_byte;
                op.flag = 1'b0;
                if (accept)
                    state_next = F_CMD;
            end
            F_LIT:
            begin
                op.kind = OP_LIT;
                op.data = data_byte;
                op.flag = (lit_left_reg == 8'd1);
                if (accept)
                begin
                    lit_left_next = lit_left_reg - 8'd1;
                    if (lit_left_reg == 8'd1)
                        state_next = F_CMD;
                end
            end
            default:
            begin
                state_next = F_CMD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_CMD;
            lit_left_reg <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            lit_left_reg <= lit_left_next;
        end
    end

endmodule

>>> src/rle4_queue.sv
`timescale 1ns / 1ps
// rle4_queue: short request queue between parser and row builder.
// Depends on rle4_pkg.
module rle4_queue
    import rle4_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  head_op,
    output logic head_valid
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    op_t              entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign full       = (count_reg == CNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> src/rle4_back.sv
`timescale 1ns / 1ps
// rle4_back: row builder; tracks rows, expands runs and packs bytes into words.
// Depends on rle4_pkg.
module rle4_back
    import rle4_pkg::*;
#(
    parameter int OUT_BYTES = OUT_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 head_op,
    input  logic                head_valid,
    output logic                pop,
    input  logic [WIDTH_W-1:0]  image_width,
    input  logic [HEIGHT_W-1:0] image_height,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         pixel_bytes,
    output logic [2:0]          byte_count,
    output logic                row_end,
    output logic                image_end,
    output logic                overrun_seen
);

    localparam int BUF_W  = OUT_BYTES * 8;
    localparam int FILL_W = $clog2(OUT_BYTES + 1);

    logic [BUF_W-1:0]    buf_reg, buf_next, buf_ins;
    logic [FILL_W-1:0]   fill_reg, fill_next, fill_inc;
    logic [ROW_W-1:0]    row_left_reg, row_left_next, row_eff, pitch;
    logic [HEIGHT_W-1:0] rows_left_reg, rows_left_next;
    logic [7:0]          run_left_reg, run_left_next;
    logic                overrun_reg, overrun_next;
    logic                skip_reg, skip_next;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         pixel_reg, pixel_next;
    logic [2:0]          count_reg, count_next;
    logic                row_end_reg, row_end_next;
    logic                image_end_reg, image_end_next;
    logic                ov_out_reg, ov_out_next;

    logic                step, do_put, row_ends, last_row, word_full;
    logic [63:0]         buf_wide;

    assign pitch     = row_pitch(image_width);
    assign step      = head_valid && (!out_valid_reg || !out_stall);
    assign fill_inc  = fill_reg + FILL_W'(1);
    assign row_ends  = (row_left_reg == ROW_W'(1));
    assign last_row  = (rows_left_reg == HEIGHT_W'(1));
    assign word_full = (fill_inc == FILL_W'(OUT_BYTES));
    assign buf_wide  = 64'(buf_ins);

    always_comb
    begin
        buf_ins = buf_reg;
        for (int i = 0; i < OUT_BYTES; i++)
        begin
            if (fill_reg == FILL_W'(i))
                buf_ins[8*i +: 8] = head_op.data;
        end
    end

    always_comb
    begin
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        row_left_next  = row_left_reg;
        rows_left_next = rows_left_reg;
        run_left_next  = run_left_reg;
        overrun_next   = overrun_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg && out_stall;
        pixel_next     = pixel_reg;
        count_next     = count_reg;
        row_end_next   = row_end_reg;
        image_end_next = image_end_reg;
        ov_out_next    = ov_out_reg;
        row_eff        = row_left_reg;
        pop            = 1'b0;
        do_put         = 1'b0;

        if (step)
        begin
            case (head_op.kind)
                OP_CMD:
                begin
                    pop = 1'b1;
                    overrun_next = overrun_reg;
                    // no rows left: this command opens a new image
                    if (rows_left_reg == '0)
                    begin
                        rows_left_next = (image_height == '0) ? HEIGHT_W'(1) : image_height;
                        row_eff        = pitch;
                        overrun_next   = 1'b0;
                    end
                    if (ROW_W'(head_op.data) > row_eff)
                        overrun_next = 1'b1;
                    row_left_next = row_eff;
                    run_left_next = head_op.data;
                    skip_next     = 1'b0;
                end
                OP_RUN:
                begin
                    if (run_left_reg == 8'd0 || row_left_reg == '0)
                    begin
                        pop           = 1'b1;
                        run_left_next = 8'd0;
                    end
                    else
                    begin
                        do_put        = 1'b1;
                        run_left_next = run_left_reg - 8'd1;
                        // a run never crosses its row end
                        if (run_left_reg == 8'd1 || row_ends)
                        begin
                            pop           = 1'b1;
                            run_left_next = 8'd0;
                        end
                    end
                end
                OP_LIT:
                begin
                    pop = 1'b1;
                    if (!skip_reg && row_left_reg != '0)
                    begin
                        do_put = 1'b1;
                        if (row_ends && !head_op.flag)
                            skip_next = 1'b1;
                    end
                    if (head_op.flag)
                        skip_next = 1'b0;
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end

        if (do_put)
        begin
            pixel_next  = buf_wide[31:0];
            count_next  = 3'(fill_inc);
            ov_out_next = overrun_reg;
            if (row_ends)
            begin
                out_valid_next = 1'b1;
                row_end_next   = 1'b1;
                image_end_next = last_row;
                rows_left_next = rows_left_reg - HEIGHT_W'(1);
                row_left_next  = last_row ? '0 : pitch;
                buf_next       = '0;
                fill_next      = '0;
            end
            else
            begin
                row_left_next = row_left_reg - ROW_W'(1);
                if (word_full)
                begin
                    out_valid_next = 1'b1;
                    row_end_next   = 1'b0;
                    image_end_next = 1'b0;
                    buf_next       = '0;
                    fill_next      = '0;
                end
                else
                begin
                    buf_next  = buf_ins;
                    fill_next = fill_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            fill_reg      <= '0;
            row_left_reg  <= '0;
            rows_left_reg <= '0;
            run_left_reg  <= 8'd0;
            overrun_reg   <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            row_left_reg  <= row_left_next;
            rows_left_reg <= rows_left_next;
            run_left_reg  <= run_left_next;
            overrun_reg   <= overrun_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg     <= pixel_next;
        count_reg     <= count_next;
        row_end_reg   <= row_end_next;
        image_end_reg <= image_end_next;
        ov_out_reg    <= ov_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_bytes  = pixel_reg;
    assign byte_count   = count_reg;
    assign row_end      = row_end_reg;
    assign image_end    = image_end_reg;
    assign overrun_seen = ov_out_reg;

endmodule

>>> src/rle4_checker.sv
`timescale 1ns / 1ps
// rle4_checker: port-level checks on the decoder output, bound to the top level.
// Depends on rle4_pkg and rle_4bpp_row_decoder.
module rle4_checker
    import rle4_pkg::*;
#(
    parameter int OUT_BYTES = OUT_BYTES_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pixel_bytes,
    input logic [2:0]  byte_count,
    input logic        row_end,
    input logic        image_end,
    input logic        overrun_seen
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_bytes)
            && $stable(byte_count) && $stable(row_end) && $stable(image_end))
        else $error("stalled word changed");

    a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> row_end)
        else $error("image end without row end");

    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !row_end |-> byte_count == 3'(OUT_BYTES))
        else $error("partial word inside a row");

    a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != 3'd1 || pixel_bytes[31:8] == 24'd0)
            && (byte_count != 3'd2 || pixel_bytes[31:16] == 16'd0)
            && (byte_count != 3'd3 || pixel_bytes[31:24] == 8'd0))
        else $error("unused bytes not zero");

    a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && overrun_seen && !image_end |=> !out_valid || overrun_seen)
        else $error("overrun flag dropped within image");

endmodule

bind rle_4bpp_row_decoder rle4_checker #(
    .OUT_BYTES (OUT_BYTES)
) u_rle4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_bytes  (pixel_bytes),
    .byte_count   (byte_count),
    .row_end      (row_end),
    .image_end    (image_end),
    .overrun_seen (overrun_seen)
);
